// ----- hw/rtl/smas_pkg.sv -----
// ----------------------------------------------------------------------------
// smas_pkg
// Shared constants and types of the stroke moving-average smoother.
// ----------------------------------------------------------------------------
package smas_pkg;

  localparam int COORD_BITS      = 16;
  localparam int MAX_HALF_WINDOW = 15;
  localparam int HW_W            = 4;
  localparam int RING_DEPTH      = 2 * MAX_HALF_WINDOW + 1;
  localparam int RING_AW         = $clog2(RING_DEPTH);
  localparam int POINT_W         = 2 * COORD_BITS;
  localparam int SUM_W           = COORD_BITS + $clog2(RING_DEPTH);
  localparam int DIV_W           = HW_W + 1;
  localparam int STEP_W          = $clog2(SUM_W + 1);
  localparam int BACK_W          = RING_AW + 1;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  // register index taken from paddr bit 2 (byte address 4*i)
  localparam logic REG_HALF_WINDOW = 1'b0;
  localparam logic [HW_W-1:0] HALF_WINDOW_RST = HW_W'(2);

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

endpackage

// ----- hw/rtl/smas_ram.sv -----
// ----------------------------------------------------------------------------
// smas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/smas_div.sv -----
// ----------------------------------------------------------------------------
// smas_div
// Radix-2 restoring divider, one quotient bit per cycle for both coordinate
// sums in parallel against the common window size.
// ----------------------------------------------------------------------------
module smas_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [smas_pkg::SUM_W-1:0]    dvd_x_i,
  input  logic [smas_pkg::SUM_W-1:0]    dvd_y_i,
  input  logic [smas_pkg::DIV_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [smas_pkg::COORD_BITS-1:0] quot_x_o,
  output logic [smas_pkg::COORD_BITS-1:0] quot_y_o
);
  import smas_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [SUM_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [DIV_W-1:0]  rx_q, rx_d, ry_q, ry_d;
  logic [DIV_W:0]    tx, ty;
  logic              gx, gy;

  always_comb begin
    tx = {rx_q, dx_q[SUM_W-1]};
    ty = {ry_q, dy_q[SUM_W-1]};
    gx = tx >= {1'b0, div_q};
    gy = ty >= {1'b0, div_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    div_d  = div_q;
    dx_d   = dx_q;
    dy_d   = dy_q;
    rx_d   = rx_q;
    ry_d   = ry_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      div_d  = divisor_i;
      dx_d   = dvd_x_i;
      dy_d   = dvd_y_i;
      rx_d   = '0;
      ry_d   = '0;
    end else if (busy_q) begin
      rx_d = gx ? DIV_W'(tx - {1'b0, div_q}) : tx[DIV_W-1:0];
      ry_d = gy ? DIV_W'(ty - {1'b0, div_q}) : ty[DIV_W-1:0];
      dx_d = {dx_q[SUM_W-2:0], gx};
      dy_d = {dy_q[SUM_W-2:0], gy};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
  end

  assign done_o   = done_q;
  assign quot_x_o = dx_q[COORD_BITS-1:0];
  assign quot_y_o = dy_q[COORD_BITS-1:0];

endmodule

// ----- hw/rtl/stroke_moving_average_smoother_top.sv -----
// ----------------------------------------------------------------------------
// stroke_moving_average_smoother_top
// Centered moving average over pen strokes with edge replication.
// ----------------------------------------------------------------------------
// Each output point is the truncated mean of the 2K+1 stroke points around
// it (K = half_window), the first and last stroke points standing in past the
// stroke edges. Outputs trail the input by K points; a point with tlast set
// flushes the rest of the stroke, and the output with tlast ends the stroke.
// The input is taken only while the block is idle. Each result is made in
// steps: the point ring is read one entry per cycle through its single read
// port, a drain state lets the last read term be added, a start state loads
// the bit-serial divider, which yields 21 quotient bits and then signals
// done, and the output register is loaded; a stalled output register holds
// the block in its last state. An input that yields no result is taken
// without leaving the idle state.
module stroke_moving_average_smoother_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [smas_pkg::POINT_W-1:0]  s_axis_tdata,  // point_x, point_y
  input  logic                          s_axis_tuser,  // pen_is_down
  input  logic                          s_axis_tlast,  // stroke_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [smas_pkg::POINT_W-1:0]  m_axis_tdata,  // smooth_x, smooth_y
  output logic                          m_axis_tuser,  // pen_down_out
  output logic                          m_axis_tlast,  // stroke_done
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smas_pkg::PADDR_W-1:0]  paddr,
  input  logic [smas_pkg::PDATA_W-1:0]  pwdata,
  output logic [smas_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import smas_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [HW_W-1:0]    hw_q;
  logic [HW_W-1:0]    k_q, k_d, lag_q, lag_d, k_cur;
  logic [RING_AW-1:0] j_q, j_d, head_q, head_d, ps_q, ps_d, ps_new;
  logic               pen_q, pen_d, last_q, last_d;
  point_t             first_q, first_d;
  logic [SUM_W-1:0]   accx_q, accx_d, accy_q, accy_d;
  logic               pend_q, pend_d, pfirst_q, pfirst_d;
  logic               ovalid_q, ovalid_d;
  point_t             odata_q, odata_d;
  logic               open_q, open_d, olast_q, olast_d;

  logic               in_xfer, cfg_wr;
  logic signed [BACK_W-1:0] back_s;
  logic [RING_AW-1:0] back_u, raddr;
  logic [RING_AW:0]   slot_t;
  logic               use_first;
  point_t             rdata, term, in_pt;
  logic               div_start, div_done;
  logic [COORD_BITS-1:0] qx, qy;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HALF_WINDOW) ? PDATA_W'(hw_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HALF_WINDOW_RST;
    end else if (cfg_wr && paddr[2] == REG_HALF_WINDOW) begin
      hw_q <= pwdata[HW_W-1:0];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_pt         = s_axis_tdata;
  assign k_cur = (hw_q > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : hw_q;
  assign ps_new = (ps_q < RING_AW'(RING_DEPTH)) ? ps_q + RING_AW'(1) : ps_q;

  // window term address
  always_comb begin
    back_s = $signed({{(BACK_W-HW_W){1'b0}}, lag_q})
           - $signed({{(BACK_W-HW_W){1'b0}}, k_q})
           + $signed({{(BACK_W-RING_AW){1'b0}}, j_q});
    back_u    = back_s[BACK_W-1] ? '0 : back_s[RING_AW-1:0];
    use_first = back_u >= ps_q;
    slot_t    = {1'b0, head_q} + (RING_AW+1)'(RING_DEPTH - 1) - {1'b0, back_u};
    raddr     = (slot_t >= (RING_AW+1)'(RING_DEPTH))
              ? RING_AW'(slot_t - (RING_AW+1)'(RING_DEPTH)) : slot_t[RING_AW-1:0];
  end

  smas_ram #(
    .WIDTH (POINT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (head_q),
    .wdata_i (in_pt),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign term      = pfirst_q ? first_q : rdata;
  assign div_start = (state_q == ST_START);

  smas_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dvd_x_i   (accx_q),
    .dvd_y_i   (accy_q),
    .divisor_i ({k_q, 1'b1}),
    .done_o    (div_done),
    .quot_x_o  (qx),
    .quot_y_o  (qy)
  );

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    lag_d    = lag_q;
    j_d      = j_q;
    head_d   = head_q;
    ps_d     = ps_q;
    pen_d    = pen_q;
    last_d   = last_q;
    first_d  = first_q;
    accx_d   = accx_q;
    accy_d   = accy_q;
    pend_d   = 1'b0;
    pfirst_d = use_first;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    open_d   = open_q;
    olast_d  = olast_q;

    if (pend_q) begin
      accx_d = accx_q + SUM_W'(term.x);
      accy_d = accy_q + SUM_W'(term.y);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (ps_q == '0) begin
            first_d = in_pt;
          end
          head_d = (head_q == RING_AW'(RING_DEPTH - 1)) ? '0 : head_q + RING_AW'(1);
          ps_d   = ps_new;
          k_d    = k_cur;
          pen_d  = s_axis_tuser;
          last_d = s_axis_tlast;
          j_d    = '0;
          accx_d = '0;
          accy_d = '0;
          if (s_axis_tlast) begin
            lag_d   = (ps_new - RING_AW'(1) > RING_AW'(k_cur))
                    ? k_cur : HW_W'(ps_new - RING_AW'(1));
            state_d = ST_SUM;
          end else if (ps_new > RING_AW'(k_cur)) begin
            lag_d   = k_cur;
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        pend_d = 1'b1;
        j_d    = j_q + RING_AW'(1);
        if (j_q == RING_AW'({k_q, 1'b0})) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = '{y: qy, x: qx};
          open_d   = pen_q;
          olast_d  = last_q && (lag_q == '0);
          if (last_q && lag_q != '0) begin
            lag_d   = lag_q - HW_W'(1);
            j_d     = '0;
            accx_d  = '0;
            accy_d  = '0;
            state_d = ST_SUM;
          end else begin
            if (last_q) begin
              ps_d = '0;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      ps_q     <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      ps_q     <= ps_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    lag_q    <= lag_d;
    j_q      <= j_d;
    pen_q    <= pen_d;
    last_q   <= last_d;
    first_q  <= first_d;
    accx_q   <= accx_d;
    accy_q   <= accy_d;
    pfirst_q <= pfirst_d;
    odata_q  <= odata_d;
    open_q   <= open_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = open_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ----- hw/rtl/smas_checker.sv -----
// ----------------------------------------------------------------------------
// smas_checker
// Port-level checks of the stroke smoother, bound to the top level.
// ----------------------------------------------------------------------------
module smas_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [smas_pkg::POINT_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [smas_pkg::PADDR_W-1:0]  paddr,
  input logic [smas_pkg::PDATA_W-1:0]  pwdata,
  input logic [smas_pkg::PDATA_W-1:0]  prdata,
  input logic                          pready
);
  import smas_pkg::*;

  // a stroke end always keeps the block busy
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken while a stroke end is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // written half window reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_HALF_WINDOW |=>
      paddr[2] != REG_HALF_WINDOW || prdata == PDATA_W'($past(pwdata[HW_W-1:0])))
    else $error("half window readback mismatch");

endmodule

bind stroke_moving_average_smoother_top smas_checker u_smas_checker (.*);
